// ===== rtl/lrfa_pkg.sv =====
`timescale 1ns / 1ps

package lrfa_pkg;

  // Fixed point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CUT_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = CFG_IDX_W'(1);

  // Reset values: cutoff about 0.03, fallback 2000.0
  localparam longint unsigned CUTOFF_RST_L   = (64'd3 << FRAC_BITS) / 64'd100;
  localparam longint unsigned FALLBACK_RST_L = 64'd2000 << FRAC_BITS;
  localparam logic [CUT_W-1:0]  CUTOFF_RST   = CUT_W'(CUTOFF_RST_L);
  localparam logic [DATA_W-1:0] FALLBACK_RST = DATA_W'(FALLBACK_RST_L);

  // Datapath widths
  localparam int MAG_W     = DATA_W + 1;            // sqrt of three squares
  localparam int SUMSQ_W   = 2 * DATA_W + 2;        // r^2 + g^2 + b^2
  localparam int TGT_W     = MAG_W + FRAC_BITS;     // target level
  localparam int HI_W      = TGT_W - DATA_W;        // upper slice of |T - C|
  localparam int PROD_W    = DATA_W + TGT_W;        // Q * |T - C|
  localparam int DISC_W    = PROD_W + 3;            // L^2 + 4 * Q * (T - C)
  localparam int SQ_ROOT_W = (DISC_W + 1) / 2;      // root bits, one per stage
  localparam int SQ_IN_W   = 2 * SQ_ROOT_W;
  localparam int NUM_W     = TGT_W + FRAC_BITS;     // dividend, one bit per stage
  localparam int DEN_W     = DATA_W + 1;            // divisor up to 2 * Q

  typedef enum logic [1:0] {
    CASE_GIVEN,
    CASE_LINEAR,
    CASE_QUAD,
    CASE_FALLBACK
  } case_e;

  // Sideband ahead of the discriminant
  typedef struct packed {
    logic [DATA_W-1:0] given;
    logic [DATA_W-1:0] con;
    logic [DATA_W-1:0] lin;
    logic [DATA_W-1:0] quad;
  } front_t;

  // Sideband from the discriminant to the final divide
  typedef struct packed {
    logic [DATA_W-1:0] given;
    logic [DATA_W-1:0] lin;
    logic [DATA_W-1:0] quad;
    logic              diff_neg;
    logic [TGT_W-1:0]  diff_abs;
    logic              disc_neg;
  } mid_t;

  // Sideband through the final divide
  typedef struct packed {
    logic              bypass;
    case_e             kind;
    logic [DATA_W-1:0] radius;
  } tail_t;

  localparam int FRONT_W = $bits(front_t);
  localparam int MID_W   = $bits(mid_t);
  localparam int TAIL_W  = $bits(tail_t);
  localparam int SIDE_A  = (FRONT_W > MID_W) ? FRONT_W : MID_W;
  localparam int SIDE_W  = (SIDE_A > TAIL_W) ? SIDE_A : TAIL_W;

endpackage

// ===== rtl/light_radius_from_attenuation_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// in       in_valid_i / in_stall_o    given_radius_i, intensity_*_i, *_atten_i
// out      out_valid_o / out_stall_i  light_radius_o, case_taken_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One light per cycle while the output buffer has room. Two square roots
// at one root bit per stage and two divides at one quotient bit per stage
// make up nearly all of the pipeline.
// Reset clears all valid bits and the output buffer and loads the default
// cutoff and fallback radius. A stall on the output freezes the pipeline
// only once the two-entry output buffer is full; input is stalled then.

module light_radius_from_attenuation_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lrfa_pkg::DATA_W-1:0]    given_radius_i,
  input  logic [lrfa_pkg::DATA_W-1:0]    intensity_red_i,
  input  logic [lrfa_pkg::DATA_W-1:0]    intensity_green_i,
  input  logic [lrfa_pkg::DATA_W-1:0]    intensity_blue_i,
  input  logic [lrfa_pkg::DATA_W-1:0]    constant_atten_i,
  input  logic [lrfa_pkg::DATA_W-1:0]    linear_atten_i,
  input  logic [lrfa_pkg::DATA_W-1:0]    quadratic_atten_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lrfa_pkg::DATA_W-1:0]    light_radius_o,
  output logic [1:0]                     case_taken_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lrfa_pkg::DATA_W-1:0]    cfg_data_i
);

  localparam int DW  = lrfa_pkg::DATA_W;
  localparam int SQW = 2 * lrfa_pkg::DATA_W;
  localparam int SW  = lrfa_pkg::SIDE_W;
  localparam int FB  = lrfa_pkg::FRAC_BITS;

  // Config registers
  logic [lrfa_pkg::CUT_W-1:0] cutoff_q;
  logic [DW-1:0]              fallback_q;
  logic [lrfa_pkg::CUT_W-1:0] cut_eff;

  // Pipeline control
  logic en;
  logic pipe_push, pop;

  // Front stages
  logic              s0_vld_q, s1_vld_q;
  lrfa_pkg::front_t  s0_front_q, s1_front_q, in_front;
  logic [SQW-1:0]    sq_r_q, sq_g_q, sq_b_q;
  logic [lrfa_pkg::SUMSQ_W-1:0] sumsq_q;

  // Unit hookups
  logic                           sq1_vld, dv1_vld, dc_vld, sq2_vld, dv2_vld;
  logic [lrfa_pkg::SQ_ROOT_W-1:0] sq1_root, sq2_root;
  logic [SW-1:0]                  sq1_side, dv1_side, dc_side, sq2_side, dv2_side;
  logic [lrfa_pkg::NUM_W-1:0]     dv1_quo, dv2_quo;
  logic [lrfa_pkg::NUM_W-1:0]     dv1_num;
  logic [lrfa_pkg::DISC_W-1:0]    dc_disc;

  // Case decision ahead of the final divide
  lrfa_pkg::mid_t                 mid;
  lrfa_pkg::tail_t                tail_d, tail;
  logic [lrfa_pkg::NUM_W-1:0]     dv2_num;
  logic [lrfa_pkg::DEN_W-1:0]     dv2_den;
  logic [lrfa_pkg::SQ_ROOT_W-1:0] s_minus_l;
  logic [DW-1:0]                  result_radius;

  // Output buffer
  logic [1:0]        cnt_q;
  logic              wr_q, rd_q;
  logic [DW-1:0]     ob_radius_q [2];
  lrfa_pkg::case_e   ob_case_q [2];

  // Config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= lrfa_pkg::CUTOFF_RST;
      fallback_q <= lrfa_pkg::FALLBACK_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lrfa_pkg::REG_CUTOFF:   cutoff_q   <= cfg_data_i[lrfa_pkg::CUT_W-1:0];
        lrfa_pkg::REG_FALLBACK: fallback_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cut_eff = (cutoff_q == '0) ? lrfa_pkg::CUT_W'(1) : cutoff_q;

  // Whole pipeline advances unless the output buffer is full
  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  // Front: squares, then their sum
  always_comb begin
    in_front.given = given_radius_i;
    in_front.con   = constant_atten_i;
    in_front.lin   = linear_atten_i;
    in_front.quad  = quadratic_atten_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_front_q <= in_front;
      sq_r_q     <= SQW'(intensity_red_i) * SQW'(intensity_red_i);
      sq_g_q     <= SQW'(intensity_green_i) * SQW'(intensity_green_i);
      sq_b_q     <= SQW'(intensity_blue_i) * SQW'(intensity_blue_i);
      s1_front_q <= s0_front_q;
      sumsq_q    <= lrfa_pkg::SUMSQ_W'(sq_r_q) + lrfa_pkg::SUMSQ_W'(sq_g_q)
                  + lrfa_pkg::SUMSQ_W'(sq_b_q);
    end
  end

  // Intensity magnitude
  lrfa_sqrt u_sqrt_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_vld_q),
    .value_i (lrfa_pkg::SQ_IN_W'(sumsq_q)),
    .side_i  (SW'(s1_front_q)),
    .valid_o (sq1_vld),
    .root_o  (sq1_root),
    .side_o  (sq1_side)
  );

  // Target level: magnitude over cutoff
  assign dv1_num = lrfa_pkg::NUM_W'(sq1_root[lrfa_pkg::MAG_W-1:0]) << FB;

  lrfa_div u_div_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq1_vld),
    .num_i   (dv1_num),
    .den_i   (lrfa_pkg::DEN_W'(cut_eff)),
    .side_i  (sq1_side),
    .valid_o (dv1_vld),
    .quo_o   (dv1_quo),
    .side_o  (dv1_side)
  );

  lrfa_disc u_disc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dv1_vld),
    .target_i (dv1_quo[lrfa_pkg::TGT_W-1:0]),
    .side_i   (dv1_side),
    .valid_o  (dc_vld),
    .disc_o   (dc_disc),
    .side_o   (dc_side)
  );

  lrfa_sqrt u_sqrt_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dc_vld),
    .value_i (lrfa_pkg::SQ_IN_W'(dc_disc)),
    .side_i  (dc_side),
    .valid_o (sq2_vld),
    .root_o  (sq2_root),
    .side_o  (sq2_side)
  );

  // Pick the case and set up the final divide
  assign mid       = lrfa_pkg::mid_t'(sq2_side[lrfa_pkg::MID_W-1:0]);
  assign s_minus_l = (sq2_root >= lrfa_pkg::SQ_ROOT_W'(mid.lin))
                   ? sq2_root - lrfa_pkg::SQ_ROOT_W'(mid.lin) : '0;

  always_comb begin
    tail_d.bypass = 1'b1;
    tail_d.kind   = lrfa_pkg::CASE_GIVEN;
    tail_d.radius = '0;
    dv2_num       = '0;
    dv2_den       = lrfa_pkg::DEN_W'(1);
    priority if (mid.given != '0) begin
      tail_d.radius = mid.given;
    end else if (mid.quad == '0 && mid.lin == '0) begin
      tail_d.kind   = lrfa_pkg::CASE_FALLBACK;
      tail_d.radius = fallback_q;
    end else if (mid.quad == '0) begin
      tail_d.kind = lrfa_pkg::CASE_LINEAR;
      if (!mid.diff_neg) begin
        tail_d.bypass = 1'b0;
        dv2_num       = lrfa_pkg::NUM_W'(mid.diff_abs) << FB;
        dv2_den       = lrfa_pkg::DEN_W'(mid.lin);
      end
    end else if (mid.diff_neg) begin
      // both roots at or below zero unless the discriminant is negative
      if (mid.disc_neg) begin
        tail_d.kind   = lrfa_pkg::CASE_FALLBACK;
        tail_d.radius = fallback_q;
      end else begin
        tail_d.kind = lrfa_pkg::CASE_QUAD;
      end
    end else begin
      tail_d.kind   = lrfa_pkg::CASE_QUAD;
      tail_d.bypass = 1'b0;
      dv2_num       = lrfa_pkg::NUM_W'(s_minus_l) << FB;
      dv2_den       = {mid.quad, 1'b0};
    end
  end

  lrfa_div u_div_radius (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq2_vld),
    .num_i   (dv2_num),
    .den_i   (dv2_den),
    .side_i  (SW'(tail_d)),
    .valid_o (dv2_vld),
    .quo_o   (dv2_quo),
    .side_o  (dv2_side)
  );

  // Saturate and select the result
  assign tail = lrfa_pkg::tail_t'(dv2_side[lrfa_pkg::TAIL_W-1:0]);

  always_comb begin
    if (tail.bypass) begin
      result_radius = tail.radius;
    end else if (dv2_quo[lrfa_pkg::NUM_W-1:DW] != '0) begin
      result_radius = '1;
    end else begin
      result_radius = dv2_quo[DW-1:0];
    end
  end

  // Two-entry output buffer
  assign pipe_push = dv2_vld && en;
  assign pop       = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (pipe_push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(pipe_push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_push) begin
      ob_radius_q[wr_q] <= result_radius;
      ob_case_q[wr_q]   <= tail.kind;
    end
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign light_radius_o = ob_radius_q[rd_q];
  assign case_taken_o   = ob_case_q[rd_q];

  // Buffer never overfills
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("output buffer count out of range");

  // A full buffer under stall stays full: nothing pushed, nothing lost
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && out_stall_i) |=> cnt_q == 2'd2)
    else $error("full output buffer changed while stalled");

  // A push without a pop grows the count by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("output buffer push lost");

endmodule

// ===== rtl/lrfa_sqrt.sv =====
`timescale 1ns / 1ps

// Integer square root, one root bit per stage, restoring method
module lrfa_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [lrfa_pkg::SQ_IN_W-1:0] value_i,
  input  logic [lrfa_pkg::SIDE_W-1:0]  side_i,
  output logic                         valid_o,
  output logic [lrfa_pkg::SQ_ROOT_W-1:0] root_o,
  output logic [lrfa_pkg::SIDE_W-1:0]  side_o
);

  localparam int N  = lrfa_pkg::SQ_ROOT_W;
  localparam int RW = lrfa_pkg::SQ_ROOT_W + 2;
  localparam int IW = lrfa_pkg::SQ_IN_W;
  localparam int SW = lrfa_pkg::SIDE_W;

  logic [N-1:0]  vld_q;
  logic [RW-1:0] rem_q [N];
  logic [RW-1:0] rem_d [N];
  logic [RW-1:0] rem_in [N];
  logic [N-1:0]  root_q [N];
  logic [N-1:0]  root_d [N];
  logic [N-1:0]  root_in [N];
  logic [IW-1:0] val_q [N];
  logic [IW-1:0] val_d [N];
  logic [IW-1:0] val_in [N];
  logic [SW-1:0] side_q [N];

  // Stage inputs: the port for stage 0, the previous stage otherwise
  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    val_in[0]  = value_i;
    for (int k = 1; k < N; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      val_in[k]  = val_q[k-1];
    end
  end

  // One trial subtract per stage
  always_comb begin
    logic [RW-1:0] rw;
    logic [RW-1:0] trial;
    for (int k = 0; k < N; k++) begin
      rw    = {rem_in[k][RW-3:0], val_in[k][IW-1 -: 2]};
      trial = {root_in[k], 2'b01};
      if (rw >= trial) begin
        rem_d[k]  = rw - trial;
        root_d[k] = {root_in[k][N-2:0], 1'b1};
      end else begin
        rem_d[k]  = rw;
        root_d[k] = {root_in[k][N-2:0], 1'b0};
      end
      val_d[k] = val_in[k] << 2;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 0; k < N; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        val_q[k]  <= val_d[k];
      end
      for (int k = 1; k < N; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ===== rtl/lrfa_div.sv =====
`timescale 1ns / 1ps

// Unsigned divide, one quotient bit per stage, restoring method
module lrfa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [lrfa_pkg::NUM_W-1:0]  num_i,
  input  logic [lrfa_pkg::DEN_W-1:0]  den_i,
  input  logic [lrfa_pkg::SIDE_W-1:0] side_i,
  output logic                        valid_o,
  output logic [lrfa_pkg::NUM_W-1:0]  quo_o,
  output logic [lrfa_pkg::SIDE_W-1:0] side_o
);

  localparam int N  = lrfa_pkg::NUM_W;
  localparam int DW = lrfa_pkg::DEN_W;
  localparam int RW = lrfa_pkg::DEN_W + 1;
  localparam int SW = lrfa_pkg::SIDE_W;

  logic [N-1:0]  vld_q;
  logic [RW-1:0] rem_q [N];
  logic [RW-1:0] rem_d [N];
  logic [RW-1:0] rem_in [N];
  // dividend shifts out the top while quotient bits shift in below
  logic [N-1:0]  nq_q [N];
  logic [N-1:0]  nq_d [N];
  logic [N-1:0]  nq_in [N];
  logic [DW-1:0] den_q [N];
  logic [DW-1:0] den_in [N];
  logic [SW-1:0] side_q [N];

  always_comb begin
    rem_in[0] = '0;
    nq_in[0]  = num_i;
    den_in[0] = den_i;
    for (int k = 1; k < N; k++) begin
      rem_in[k] = rem_q[k-1];
      nq_in[k]  = nq_q[k-1];
      den_in[k] = den_q[k-1];
    end
  end

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    logic [RW-1:0] rw;
    logic          fit;
    for (int k = 0; k < N; k++) begin
      rw  = {rem_in[k][RW-2:0], nq_in[k][N-1]};
      fit = (rw >= RW'(den_in[k]));
      rem_d[k] = fit ? rw - RW'(den_in[k]) : rw;
      nq_d[k]  = {nq_in[k][N-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
        den_q[k] <= den_in[k];
      end
      for (int k = 1; k < N; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = nq_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ===== rtl/lrfa_disc.sv =====
`timescale 1ns / 1ps

// T - C, then the discriminant L^2 + 4 * Q * (T - C) over four stages
module lrfa_disc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [lrfa_pkg::TGT_W-1:0]  target_i,
  input  logic [lrfa_pkg::SIDE_W-1:0] side_i,
  output logic                        valid_o,
  output logic [lrfa_pkg::DISC_W-1:0] disc_o,
  output logic [lrfa_pkg::SIDE_W-1:0] side_o
);

  localparam int DW  = lrfa_pkg::DATA_W;
  localparam int TW  = lrfa_pkg::TGT_W;
  localparam int HW  = lrfa_pkg::HI_W;
  localparam int PW  = lrfa_pkg::PROD_W;
  localparam int XW  = lrfa_pkg::DISC_W;
  localparam int SQW = 2 * lrfa_pkg::DATA_W;
  localparam int PHW = lrfa_pkg::DATA_W + lrfa_pkg::HI_W;

  lrfa_pkg::front_t front;
  lrfa_pkg::mid_t   m1_d, m1_q, m2_q, m3_q, m4_d, m4_q;
  logic [TW-1:0]    con_x;
  logic [3:0]       vld_q;
  logic [SQW-1:0]   l2_q2, l2_q3;
  logic [SQW-1:0]   plo_q;
  logic [PHW-1:0]   phi_q;
  logic [PW-1:0]    prod_q;
  logic [XW-1:0]    four_prod, l2_x, disc_q;

  // Stage 1: signed difference as sign and magnitude
  assign front = lrfa_pkg::front_t'(side_i[lrfa_pkg::FRONT_W-1:0]);
  assign con_x = TW'(front.con);

  always_comb begin
    m1_d          = '0;
    m1_d.given    = front.given;
    m1_d.lin      = front.lin;
    m1_d.quad     = front.quad;
    m1_d.diff_neg = (target_i < con_x);
    m1_d.diff_abs = m1_d.diff_neg ? con_x - target_i : target_i - con_x;
  end

  // Stage 4: sum and sign of the discriminant
  assign four_prod = XW'(prod_q) << 2;
  assign l2_x      = XW'(l2_q3);

  always_comb begin
    m4_d          = m3_q;
    m4_d.disc_neg = m3_q.diff_neg && (l2_x < four_prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= m1_d;
      // Stage 2: three products, upper slice split off
      m2_q   <= m1_q;
      l2_q2  <= SQW'(m1_q.lin) * SQW'(m1_q.lin);
      plo_q  <= SQW'(m1_q.quad) * SQW'(m1_q.diff_abs[DW-1:0]);
      phi_q  <= PHW'(m1_q.quad) * PHW'(m1_q.diff_abs[TW-1:DW]);
      // Stage 3: recombine Q * |T - C|
      m3_q   <= m2_q;
      l2_q3  <= l2_q2;
      prod_q <= (PW'(phi_q) << DW) + PW'(plo_q);
      // Stage 4
      m4_q   <= m4_d;
      disc_q <= l2_x + four_prod;
    end
  end

  assign valid_o = vld_q[3];
  assign disc_o  = disc_q;
  assign side_o  = lrfa_pkg::SIDE_W'(m4_q);

endmodule

// ===== tb/tb_light_radius_from_attenuation_unit.sv =====
`timescale 1ns / 1ps

module tb_light_radius_from_attenuation_unit;

  typedef struct {
    logic [lrfa_pkg::DATA_W-1:0] given;
    logic [lrfa_pkg::DATA_W-1:0] red;
    logic [lrfa_pkg::DATA_W-1:0] green;
    logic [lrfa_pkg::DATA_W-1:0] blue;
    logic [lrfa_pkg::DATA_W-1:0] con;
    logic [lrfa_pkg::DATA_W-1:0] lin;
    logic [lrfa_pkg::DATA_W-1:0] quad;
  } light_t;

  typedef struct {
    logic [lrfa_pkg::DATA_W-1:0] radius;
    lrfa_pkg::case_e             kind;
  } radius_t;

  localparam int DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  light_t cur = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic [lrfa_pkg::DATA_W-1:0] radius_o;
  logic [1:0] case_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lrfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lrfa_pkg::DATA_W-1:0] cfg_data = '0;

  light_t lights_q[$];
  radius_t radii_q[$];
  logic [lrfa_pkg::CUT_W-1:0] cutoff = lrfa_pkg::CUTOFF_RST;
  logic [lrfa_pkg::DATA_W-1:0] fallback = lrfa_pkg::FALLBACK_RST;
  logic took = 1'b0;
  logic hold = 1'b0;
  logic running = 1'b0;
  int src_idle = 0;
  int snk_stall = 0;
  int errors = 0;

  light_radius_from_attenuation_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .given_radius_i    (cur.given),
    .intensity_red_i   (cur.red),
    .intensity_green_i (cur.green),
    .intensity_blue_i  (cur.blue),
    .constant_atten_i  (cur.con),
    .linear_atten_i    (cur.lin),
    .quadratic_atten_i (cur.quad),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .light_radius_o    (radius_o),
    .case_taken_o      (case_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bitwise integer square root, floor
  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if (v >= 128'(cand) * 128'(cand)) res = cand;
    end
    return res;
  endfunction

  // Floor divide, saturated to the radius width
  function automatic logic [lrfa_pkg::DATA_W-1:0] div_sat(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    q = n / 128'(d);
    return (q[127:32] != '0) ? '1 : q[31:0];
  endfunction

  function automatic radius_t light_radius(light_t l);
    radius_t r;
    logic [127:0] sumsq;
    logic [63:0] mag;
    logic [63:0] cut;
    logic [63:0] tgt;
    logic [127:0] lsq;
    logic [127:0] four_qc;
    logic [63:0] root;
    cut = (cutoff == '0) ? 64'd1 : 64'(cutoff);
    if (l.given != '0) begin
      r.radius = l.given;
      r.kind = lrfa_pkg::CASE_GIVEN;
      return r;
    end
    sumsq = 128'(l.red) * l.red + 128'(l.green) * l.green + 128'(l.blue) * l.blue;
    mag = isqrt(sumsq);
    tgt = (mag << lrfa_pkg::FRAC_BITS) / cut;
    lsq = 128'(l.lin) * l.lin;
    if (l.quad == '0) begin
      if (l.lin == '0) begin
        r.radius = fallback;
        r.kind = lrfa_pkg::CASE_FALLBACK;
      end else begin
        r.kind = lrfa_pkg::CASE_LINEAR;
        r.radius = (tgt < l.con) ? '0
                 : div_sat(128'(tgt - l.con) << lrfa_pkg::FRAC_BITS, 64'(l.lin));
      end
    end else if (tgt < l.con) begin
      four_qc = (128'(l.quad) * (64'(l.con) - tgt)) << 2;
      if (lsq < four_qc) begin
        r.radius = fallback;
        r.kind = lrfa_pkg::CASE_FALLBACK;
      end else begin
        r.radius = '0;
        r.kind = lrfa_pkg::CASE_QUAD;
      end
    end else begin
      four_qc = (128'(l.quad) * (tgt - l.con)) << 2;
      root = isqrt(lsq + four_qc);
      r.kind = lrfa_pkg::CASE_QUAD;
      r.radius = div_sat(128'((root >= l.lin) ? root - l.lin : 64'd0) << lrfa_pkg::FRAC_BITS,
                         64'(l.quad) << 1);
    end
    return r;
  endfunction

  // Mixed magnitudes so every case gets reached
  function automatic logic [lrfa_pkg::DATA_W-1:0] rnd_val();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return $urandom_range(32'hFFFFF);
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic light_t rnd_light();
    light_t l;
    l.given = ($urandom_range(9) < 2) ? rnd_val() : '0;
    l.red = rnd_val();
    l.green = rnd_val();
    l.blue = rnd_val();
    l.con = rnd_val();
    l.lin = ($urandom_range(9) < 2) ? '0 : rnd_val();
    l.quad = ($urandom_range(9) < 3) ? '0 : rnd_val();
    return l;
  endfunction

  // Input transfers and expected radii
  always @(posedge clk_i) begin
    took <= in_valid && !in_stall;
    if (in_valid && !in_stall) radii_q.push_back(light_radius(cur));
    if (out_valid && !out_stall) begin
      if (radii_q.size() == 0) begin
        $error("unexpected result radius %0h case %0d", radius_o, case_o);
        errors++;
      end else begin
        radius_t e;
        e = radii_q.pop_front();
        if (radius_o !== e.radius) begin
          $error("light_radius expected %0h actual %0h", e.radius, radius_o);
          errors++;
        end
        if (case_o !== e.kind) begin
          $error("case_taken expected %0d actual %0d", e.kind, case_o);
          errors++;
        end
      end
    end
  end

  // Driver: new item after each transfer, random gaps and stalls
  always @(negedge clk_i) begin
    if (running) begin
      if (!in_valid || took) begin
        if (lights_q.size() > 0 && !hold && $urandom_range(99) >= src_idle) begin
          cur <= lights_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < snk_stall);
    end
  end

  task automatic drain();
    while (lights_q.size() != 0 || in_valid || radii_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lrfa_pkg::CFG_IDX_W-1:0] idx,
                           logic [lrfa_pkg::DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (idx == lrfa_pkg::REG_CUTOFF) cutoff = val[lrfa_pkg::CUT_W-1:0];
    else if (idx == lrfa_pkg::REG_FALLBACK) fallback = val;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic push(logic [31:0] g, logic [31:0] r, logic [31:0] gr, logic [31:0] b,
                      logic [31:0] c, logic [31:0] l, logic [31:0] q);
    light_t x;
    x = '{g, r, gr, b, c, l, q};
    lights_q.push_back(x);
  endtask

  initial begin
    int cut_set[6];
    logic [31:0] fb_set[6];
    cut_set = '{16'hFFFF, 1, 0, 1966, 0, 1};
    fb_set = '{32'h0, 32'hFFFFFFFF, 32'h12345678, 32'h0, 32'h0, 32'h0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    running <= 1'b1;

    // Directed: given radius, fallback, linear, quadratic, saturation
    push('1, 0, 0, 0, 0, 0, 0);
    push(1, 5, 5, 5, 0, 0, 0);
    push(0, 0, 0, 0, 0, 0, 0);
    push(0, '1, '1, '1, 0, 0, 0);
    push(0, '1, '1, '1, 0, 1, 0);
    push(0, 32'h10000, 0, 0, '1, 32'h10000, 0);
    push(0, 32'h10000, 0, 0, 32'h8000, 32'h10000, 0);
    push(0, 0, 0, 0, '1, 0, 1);
    push(0, 0, 0, 0, '1, '1, 1);
    push(0, 32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h800, 32'h100);
    push(0, '1, '1, '1, 0, 0, 1);
    push(0, '1, '1, '1, '1, '1, '1);
    push(0, '1, 0, '1, 0, '1, '1);
    push(0, 1, 1, 1, 1, 1, 1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(lrfa_pkg::REG_CUTOFF, (p == 3) ? $urandom_range(1, 65535) : cut_set[p]);
      write_reg(lrfa_pkg::REG_FALLBACK, (p == 3 || p == 4) ? $urandom : fb_set[p]);
      if (p == 2) write_reg(lrfa_pkg::CFG_IDX_W'(2), $urandom);
      if (p == 4) write_reg(lrfa_pkg::CFG_IDX_W'(3), $urandom);
      if (p == 5) begin
        write_reg(lrfa_pkg::REG_CUTOFF, lrfa_pkg::DATA_W'(lrfa_pkg::CUTOFF_RST));
        write_reg(lrfa_pkg::REG_FALLBACK, lrfa_pkg::FALLBACK_RST);
      end
      case (p % 4)
        0: begin src_idle = 0; snk_stall = 0; end
        1: begin src_idle = 53; snk_stall = 0; end
        2: begin src_idle = 0; snk_stall = 53; end
        default: begin src_idle = 14; snk_stall = 14; end
      endcase
      for (int i = 0; i < 75; i++) lights_q.push_back(rnd_light());
      if (p == 2) begin
        // hold the sender until the pipeline has emptied
        while (lights_q.size() != 0 || in_valid) @(posedge clk_i);
        hold = 1'b1;
        while (radii_q.size() != 0) @(posedge clk_i);
        hold = 1'b0;
      end
      for (int i = 0; i < 75; i++) lights_q.push_back(rnd_light());
      drain();
    end

    if (errors == 0) begin
      $display("[light_radius_from_attenuation_unit] OK");
    end else begin
      $display("[light_radius_from_attenuation_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[light_radius_from_attenuation_unit] ERROR");
    $finish;
  end

endmodule
